// ----- rtl/base32_string_decoder_core_assert.svh -----
// Assertion macros for the base32 decoder checker
`ifndef BASE32_STRING_DECODER_CORE_ASSERT_SVH
`define BASE32_STRING_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define B32D_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define B32D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/b32d_pkg.sv -----
// Types, constants and helper functions for the base32 string decoder
package b32d_pkg;

    localparam logic [7:0] CHAR_PAD     = 8'h3D;
    localparam logic [7:0] CHAR_UP_A    = 8'h41;
    localparam logic [7:0] CHAR_UP_Z    = 8'h5A;
    localparam logic [7:0] CHAR_LO_A    = 8'h61;
    localparam logic [7:0] CHAR_LO_Z    = 8'h7A;
    localparam logic [7:0] CHAR_TWO     = 8'h32;
    localparam logic [7:0] CHAR_SEVEN   = 8'h37;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_ONE     = 8'h31;
    localparam logic [7:0] CHAR_EIGHT   = 8'h38;

    localparam logic [5:0] CODE_INVALID = 6'd32;
    localparam logic [5:0] CODE_O       = 6'd14;
    localparam logic [5:0] CODE_L       = 6'd11;
    localparam logic [5:0] CODE_B       = 6'd1;
    localparam logic [5:0] CODE_DIGIT   = 6'd26;

    localparam logic [2:0] SLOT_FIRST   = 3'd0;
    localparam logic [2:0] SLOT_PAD_1   = 3'd2;
    localparam logic [2:0] SLOT_PAD_2   = 3'd4;
    localparam logic [2:0] SLOT_PAD_3   = 3'd5;
    localparam logic [2:0] SLOT_LAST    = 3'd7;

    localparam logic [2:0] GROUP_BYTES  = 3'd5;

    localparam logic [15:0] BYTE_CAP_RESET = 16'hFFFF;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    typedef struct packed {
        logic [7:0] character;
        logic       final_char;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_status;
        logic        failed;
        logic [15:0] byte_count;
        logic        end_of_run;
    } out_word_t;

    typedef struct packed {
        logic [39:0] group_bits;
        logic [2:0]  byte_num;
        logic        has_status;
        logic        failed;
        logic [15:0] byte_count;
    } record_t;

    typedef struct packed {
        logic    push;
        record_t rec;
    } front_req_t;

    function automatic logic [5:0] char_value(input logic [7:0] ch);
        logic [7:0] diff;
        diff = 8'd0;
        char_value = CODE_INVALID;
        if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z)
        begin
            diff = ch - CHAR_UP_A;
            char_value = {1'b0, diff[4:0]};
        end
        else if (ch >= CHAR_LO_A && ch <= CHAR_LO_Z)
        begin
            diff = ch - CHAR_LO_A;
            char_value = {1'b0, diff[4:0]};
        end
        else if (ch >= CHAR_TWO && ch <= CHAR_SEVEN)
        begin
            diff = ch - CHAR_TWO;
            char_value = CODE_DIGIT + {3'b000, diff[2:0]};
        end
        else if (ch == CHAR_ZERO)
            char_value = CODE_O;
        else if (ch == CHAR_ONE)
            char_value = CODE_L;
        else if (ch == CHAR_EIGHT)
            char_value = CODE_B;
        else if (ch == CHAR_PAD)
            char_value = 6'd0;
    endfunction

    function automatic logic pad_slot_ok(input logic [2:0] slot);
        pad_slot_ok = (slot == SLOT_PAD_1) || (slot == SLOT_PAD_2) ||
                      (slot == SLOT_PAD_3) || (slot == SLOT_LAST);
    endfunction

    function automatic logic [2:0] pad_bytes(input logic [2:0] slot);
        case (slot)
            SLOT_PAD_1: pad_bytes = 3'd1;
            SLOT_PAD_2: pad_bytes = 3'd2;
            SLOT_PAD_3: pad_bytes = 3'd3;
            default:    pad_bytes = 3'd4;
        endcase
    endfunction

    function automatic logic [7:0] byte_of(input logic [39:0] bits, input logic [2:0] idx);
        case (idx)
            3'd0:    byte_of = bits[39:32];
            3'd1:    byte_of = bits[31:24];
            3'd2:    byte_of = bits[23:16];
            3'd3:    byte_of = bits[15:8];
            3'd4:    byte_of = bits[7:0];
            default: byte_of = 8'd0;
        endcase
    endfunction

endpackage

// ----- rtl/base32_string_decoder_core.sv -----
// Top level of the base32 string decoder
//
// Input queue port: one character word per push, accepted when push is high and full low;
// final_char marks the last character of a string.
// Output queue port: while empty is low the oldest result word is on dout; pop takes it.
// Each complete group of eight characters gives up to five data words, most significant
// byte first; the last character adds one status word with pass or fail and byte count.
// end_of_run marks the last word caused by one character.
// Throughput: one character per cycle while full is low, set by the combinational
// decode front end; the output side drains one word per cycle while pop is high, from
// a queue of QUEUE_DEPTH group records. An accepted character's record is written into
// the queue and then loaded into the back end's record register, which drives dout.
// A receiver stall fills the record queue, after which full rises and input waits.
// cfg_we/cfg_data write the byte capacity; write only while the block is idle.
// Reset: queue empty, decode state cleared, byte capacity 65535.
module base32_string_decoder_core
#(
    parameter int unsigned QUEUE_DEPTH = b32d_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  b32d_pkg::in_word_t  din,
    input  logic                pop,
    output logic                empty,
    output b32d_pkg::out_word_t dout,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data
);

    b32d_pkg::front_req_t req;
    b32d_pkg::record_t    q_rec;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;
    logic                 accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    b32d_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .din      (din),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req)
    );

    b32d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (req.push),
        .wr_rec  (req.rec),
        .rd_en   (q_pop),
        .rd_rec  (q_rec),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    b32d_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_rec   (q_rec),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .dout    (dout)
    );

endmodule

// ----- rtl/b32d_front.sv -----
// Front end: character decode, group packing and error tracking, one character per cycle while accept is high
module b32d_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  b32d_pkg::in_word_t  din,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data,
    output b32d_pkg::front_req_t req
);

    logic [15:0] cap_reg;
    logic [39:0] bits_reg,  bits_next;
    logic [2:0]  slot_reg,  slot_next;
    logic        pad_reg,   pad_next;
    logic [2:0]  pslot_reg, pslot_next;
    logic        err_reg,   err_next;
    logic [15:0] cnt_reg,   cnt_next;

    logic [5:0]  val;
    logic [39:0] shifted;
    logic [2:0]  nb;
    logic [16:0] need;

    always_comb
    begin
        val        = b32d_pkg::char_value(din.character);
        shifted    = {bits_reg[34:0], val[4:0]};
        need       = {1'b0, cnt_reg} + {14'd0, b32d_pkg::GROUP_BYTES};
        bits_next  = bits_reg;
        slot_next  = slot_reg;
        pad_next   = pad_reg;
        pslot_next = pslot_reg;
        err_next   = err_reg;
        cnt_next   = cnt_reg;
        nb         = 3'd0;

        if (!err_reg)
        begin
            if (val == b32d_pkg::CODE_INVALID)
                err_next = 1'b1;
            else if (pad_reg)
            begin
                if (din.character != b32d_pkg::CHAR_PAD || slot_reg == b32d_pkg::SLOT_FIRST)
                    err_next = 1'b1;
            end
            else if (din.character == b32d_pkg::CHAR_PAD)
            begin
                if (b32d_pkg::pad_slot_ok(slot_reg))
                begin
                    pad_next   = 1'b1;
                    pslot_next = slot_reg;
                end
                else
                    err_next = 1'b1;
            end

            if (!err_next)
            begin
                bits_next = shifted;
                if (slot_reg == b32d_pkg::SLOT_LAST)
                begin
                    if (need > {1'b0, cap_reg})
                        err_next = 1'b1;
                    else
                    begin
                        nb = pad_next ? b32d_pkg::pad_bytes(pslot_next)
                                      : b32d_pkg::GROUP_BYTES;
                        cnt_next = cnt_reg + {13'd0, nb};
                    end
                    bits_next = 40'd0;
                    slot_next = b32d_pkg::SLOT_FIRST;
                end
                else
                    slot_next = slot_reg + 3'd1;
            end
        end

        if (din.final_char && slot_next != b32d_pkg::SLOT_FIRST)
            err_next = 1'b1;

        req.push           = accept && (nb != 3'd0 || din.final_char);
        req.rec.group_bits = shifted;
        req.rec.byte_num   = nb;
        req.rec.has_status = din.final_char;
        req.rec.failed     = err_next;
        req.rec.byte_count = cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= b32d_pkg::BYTE_CAP_RESET;
            bits_reg  <= 40'd0;
            slot_reg  <= b32d_pkg::SLOT_FIRST;
            pad_reg   <= 1'b0;
            pslot_reg <= b32d_pkg::SLOT_FIRST;
            err_reg   <= 1'b0;
            cnt_reg   <= 16'd0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_data;
            if (accept)
            begin
                if (din.final_char)
                begin
                    bits_reg  <= 40'd0;
                    slot_reg  <= b32d_pkg::SLOT_FIRST;
                    pad_reg   <= 1'b0;
                    pslot_reg <= b32d_pkg::SLOT_FIRST;
                    err_reg   <= 1'b0;
                    cnt_reg   <= 16'd0;
                end
                else
                begin
                    bits_reg  <= bits_next;
                    slot_reg  <= slot_next;
                    pad_reg   <= pad_next;
                    pslot_reg <= pslot_next;
                    err_reg   <= err_next;
                    cnt_reg   <= cnt_next;
                end
            end
        end
    end

endmodule

// ----- rtl/b32d_queue.sv -----
// Short record queue between the decode front end and the output sequencer
module b32d_queue
#(
    parameter int unsigned DEPTH = b32d_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  b32d_pkg::record_t wr_rec,
    input  logic              rd_en,
    output b32d_pkg::record_t rd_rec,
    output logic              q_full,
    output logic              q_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b32d_pkg::record_t slots_reg [DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign q_full  = (cnt_reg == FULL_CNT);
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_rec  = slots_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CW'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slots_reg[wp_reg] <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
                wp_reg <= (wp_reg == LAST_PTR) ? '0 : wp_reg + PW'(1);
            if (do_rd)
                rp_reg <= (rp_reg == LAST_PTR) ? '0 : rp_reg + PW'(1);
        end
    end

endmodule

// ----- rtl/b32d_back.sv -----
// Back end: unrolls one record into data words and, for a final character, the closing status word
module b32d_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  b32d_pkg::record_t    q_rec,
    input  logic                 q_empty,
    output logic                 q_pop,
    input  logic                 pop,
    output logic                 empty,
    output b32d_pkg::out_word_t  dout
);

    b32d_pkg::record_t rec_reg;
    logic [2:0]        idx_reg;
    logic              busy_reg;
    logic [2:0]        total;
    logic              last_word;
    logic              status_now;
    logic              take;

    assign total      = rec_reg.byte_num + {2'b00, rec_reg.has_status};
    assign last_word  = (idx_reg == total - 3'd1);
    assign status_now = rec_reg.has_status && (idx_reg == rec_reg.byte_num);
    assign take       = pop && busy_reg;
    assign q_pop      = (!busy_reg || (take && last_word)) && !q_empty;
    assign empty      = !busy_reg;

    always_comb
    begin
        dout.data_byte  = status_now ? 8'd0 : b32d_pkg::byte_of(rec_reg.group_bits, idx_reg);
        dout.is_status  = status_now;
        dout.failed     = status_now && rec_reg.failed;
        dout.byte_count = status_now ? rec_reg.byte_count : 16'd0;
        dout.end_of_run = last_word;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            rec_reg <= q_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else if (q_pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 3'd0;
        end
        else if (take && last_word)
            busy_reg <= 1'b0;
        else if (take)
            idx_reg <= idx_reg + 3'd1;
    end

endmodule

// ----- rtl/b32d_checker.sv -----
// Port-level checker for the base32 string decoder, bound to the top level
`include "base32_string_decoder_core_assert.svh"

module b32d_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                pop,
    input logic                empty,
    input b32d_pkg::out_word_t dout
);

    `B32D_ASSERT_NEXT(a_hold_word, !empty && !pop, !empty && $stable(dout), "word changed while waiting")
    `B32D_ASSERT_NOW(a_status_ends, !empty && dout.is_status, dout.end_of_run, "status word without end_of_run")
    `B32D_ASSERT_NOW(a_data_clean, !empty && !dout.is_status, !dout.failed && dout.byte_count == 16'd0, "data word carries status fields")
    `B32D_ASSERT_NOW(a_status_zero, !empty && dout.is_status, dout.data_byte == 8'd0, "status word carries data")

endmodule

bind base32_string_decoder_core b32d_checker u_b32d_checker (.*);
